// ===== rtl/tmcs_pkg.sv =====
// ---------------------------------------------------------------------------
// tmcs_pkg
// shared types, codes and sizes of the timed measurement cycle sequencer
// ---------------------------------------------------------------------------
package tmcs_pkg;

  localparam int SCHED_SLOTS   = 10;
  localparam int SCHED_AW      = (SCHED_SLOTS > 1) ? $clog2(SCHED_SLOTS) : 1;
  localparam int SCHED_CW      = $clog2(SCHED_SLOTS + 1);
  localparam int SCHED_W       = 17;
  localparam int NFIELD        = 7;
  localparam int NSAMP         = 3;
  localparam int SAMP_DEPTH    = NFIELD * NSAMP;
  localparam int SAMP_AW       = $clog2(SAMP_DEPTH);
  localparam int GRID_WINDOW_S = 5;
  localparam int TEMP_FIELD    = 5;

  localparam logic [31:0] EPOCH_MIN   = 32'd100000;
  localparam logic [31:0] DAY_SECONDS = 32'd86400;
  localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;
  localparam logic [5:0]  MPD_MAX     = 6'd48;

  // opcodes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_TRIGGER  = 3'd2;
  localparam logic [2:0] OP_STOP     = 3'd3;
  localparam logic [2:0] OP_DOOR_OPN = 3'd4;
  localparam logic [2:0] OP_DOOR_CLS = 3'd5;
  localparam logic [2:0] OP_FAN_ON   = 3'd6;
  localparam logic [2:0] OP_FAN_OFF  = 3'd7;

  // responses
  localparam logic [3:0] RSP_NONE     = 4'd0;
  localparam logic [3:0] RSP_STARTED  = 4'd1;
  localparam logic [3:0] RSP_BUSY     = 4'd2;
  localparam logic [3:0] RSP_IN_AUTO  = 4'd3;
  localparam logic [3:0] RSP_STOPPED  = 4'd4;
  localparam logic [3:0] RSP_DOOR_OPN = 4'd5;
  localparam logic [3:0] RSP_DOOR_CLS = 4'd6;
  localparam logic [3:0] RSP_FAN_ON   = 4'd7;
  localparam logic [3:0] RSP_FAN_OFF  = 4'd8;
  localparam logic [3:0] RSP_SCHED    = 4'd9;
  localparam logic [3:0] RSP_DATA     = 4'd10;

  // cycle phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PREP = 3'd1;
  localparam logic [2:0] PH_STAB = 3'd2;
  localparam logic [2:0] PH_W1   = 3'd3;
  localparam logic [2:0] PH_W2   = 3'd4;
  localparam logic [2:0] PH_W3   = 3'd5;
  localparam logic [2:0] PH_FIN  = 3'd6;

  // register indexes
  localparam logic [2:0] REG_AUTO   = 3'd0;
  localparam logic [2:0] REG_MPD    = 3'd1;
  localparam logic [2:0] REG_STAB   = 3'd2;
  localparam logic [2:0] REG_FIRST  = 3'd3;
  localparam logic [2:0] REG_SECOND = 3'd4;
  localparam logic [2:0] REG_THIRD  = 3'd5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        epoch_seconds;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic signed [15:0] ch4_sample;
    logic signed [15:0] co_sample;
    logic signed [15:0] alcohol_sample;
    logic signed [15:0] nh3_sample;
    logic signed [15:0] h2_sample;
    logic signed [15:0] temp_sample;
    logic signed [15:0] humidity_sample;
  } in_t;

  typedef struct packed {
    logic [3:0]         response;
    logic               door_open;
    logic               fan_on;
    logic [2:0]         cycle_phase;
    logic signed [15:0] ch4_avg;
    logic signed [15:0] co_avg;
    logic signed [15:0] alcohol_avg;
    logic signed [15:0] nh3_avg;
    logic signed [15:0] h2_avg;
    logic signed [15:0] temp_avg;
    logic signed [15:0] humidity_avg;
  } out_t;

  // divider request and answer
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [16:0] rem;
  } div_rsp_t;

  function automatic logic [15:0] sample_field(input in_t d, input logic [2:0] f);
    logic [15:0] v;
    case (f)
      3'd0:    v = d.ch4_sample;
      3'd1:    v = d.co_sample;
      3'd2:    v = d.alcohol_sample;
      3'd3:    v = d.nh3_sample;
      3'd4:    v = d.h2_sample;
      3'd5:    v = d.temp_sample;
      3'd6:    v = d.humidity_sample;
      default: v = d.humidity_sample;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tmcs_ram.sv =====
// ---------------------------------------------------------------------------
// tmcs_ram
// generic single-write single-read ram with registered read data
// ---------------------------------------------------------------------------
module tmcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tmcs_div.sv =====
// ---------------------------------------------------------------------------
// tmcs_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module tmcs_div (
  input  logic                clk,
  input  logic                rst,
  input  tmcs_pkg::div_req_t  req,
  output tmcs_pkg::div_rsp_t  rsp
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] q;
  logic [16:0] r;
  logic [16:0] dvs;
  logic        done;
  logic [17:0] trial;
  logic        fits;

  assign trial = {r, q[31]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.dividend;
      r   <= 17'd0;
      dvs <= req.divisor;
    end else if (busy) begin
      q <= {q[30:0], fits};
      r <= fits ? 17'(trial - {1'b0, dvs}) : trial[16:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = r;

endmodule

// ===== rtl/timed_measurement_cycle_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// timed_measurement_cycle_sequencer_core
// measurement cycle sequencer: schedule table, grid trigger, sample averaging
// ---------------------------------------------------------------------------
//  channel  dir  handshake             beat
//  in       in   in_valid/in_ready     tmcs_pkg::in_t   (command or tick)
//  out      out  out_valid/out_ready   tmcs_pkg::out_t  (one per input beat)
//  cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data (ready while idle)
//
//  one input beat at a time; a sample latch writes all seven fields, a
//  schedule add scans the entries stored, an automatic idle tick scans them
//  and may then use the shared serial divider for grid interval and epoch
//  remainder, and the finishing tick takes seven averages, each a sample
//  store sweep plus one divide
//  synchronous reset clears control state; memories need no clearing pass
//  a result waiting in the output register only blocks the final load
// ---------------------------------------------------------------------------
module timed_measurement_cycle_sequencer_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmcs_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tmcs_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [19:0]     cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_LATCH = 8'b0001_0000,
    S_AVG   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t st;

  // configuration
  logic        auto_mode;
  logic [5:0]  mpd;
  logic [19:0] stab_ms, first_ms, second_ms, third_ms;

  // sequencer state
  logic [2:0]  phase;
  logic [19:0] elapsed;
  logic [31:0] last_epoch;
  logic        door, fan;
  logic [tmcs_pkg::SCHED_CW-1:0] sched_count;
  logic [tmcs_pkg::SCHED_AW-1:0] sched_wptr;
  logic [tmcs_pkg::NSAMP-1:0]    samp_valid;

  // working registers
  tmcs_pkg::in_t in_q;
  logic [3:0]    resp;
  logic [tmcs_pkg::SCHED_CW-1:0] scan_idx;
  logic          scan_rv;
  logic          mod_stage;
  logic [1:0]    lk;
  logic [2:0]    lf;
  logic [2:0]    af;
  logic [1:0]    step;
  logic signed [17:0] acc;
  logic          neg;
  logic [15:0]   avg [tmcs_pkg::NFIELD];

  tmcs_pkg::div_req_t div_req;
  tmcs_pkg::div_rsp_t div_rsp;

  // schedule memory
  logic [tmcs_pkg::SCHED_W-1:0] sched_rdata;
  logic [tmcs_pkg::SCHED_W-1:0] key;
  logic                         sched_we;

  // sample memory
  logic [tmcs_pkg::SAMP_AW-1:0] samp_waddr, samp_raddr;
  logic [15:0]                  samp_rdata;
  logic                         samp_we;

  assign key = {in_q.hour, in_q.minute, in_q.second};

  tmcs_ram #(.WIDTH(tmcs_pkg::SCHED_W), .DEPTH(tmcs_pkg::SCHED_SLOTS)) u_sched (
    .clk   (clk),
    .we    (sched_we),
    .waddr (sched_wptr),
    .wdata (key),
    .raddr (scan_idx[tmcs_pkg::SCHED_AW-1:0]),
    .rdata (sched_rdata)
  );

  assign samp_we    = (st == S_LATCH);
  assign samp_waddr = tmcs_pkg::SAMP_AW'(lk * tmcs_pkg::NFIELD + lf);
  assign samp_raddr = tmcs_pkg::SAMP_AW'(step * tmcs_pkg::NFIELD + af);

  tmcs_ram #(.WIDTH(16), .DEPTH(tmcs_pkg::SAMP_DEPTH)) u_samp (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_waddr),
    .wdata (tmcs_pkg::sample_field(in_q, lf)),
    .raddr (samp_raddr),
    .rdata (samp_rdata)
  );

  tmcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // scan results: a hit on the entry read last cycle, or all entries seen
  logic scan_hit, scan_end;
  assign scan_hit = scan_rv && (sched_rdata == key);
  assign scan_end = !scan_hit && (scan_idx == sched_count);
  assign sched_we = (st == S_SCAN) && scan_end && (in_q.opcode == tmcs_pkg::OP_ADD);

  // tick inside a cycle
  logic [19:0] elapsed_next;
  assign elapsed_next = (elapsed == tmcs_pkg::ELAPSED_MAX) ? elapsed : elapsed + 20'd1;

  // averaging
  logic [1:0]         vcnt;
  logic signed [17:0] acc_next;
  logic [16:0]        mag;
  logic               last_field;
  logic               step_valid;

  assign vcnt = 2'($countones(samp_valid));
  assign step_valid = (step != 2'd0) && samp_valid[step - 2'd1];
  assign acc_next = step_valid ? acc + 18'(signed'(samp_rdata)) : acc;
  assign mag  = acc_next[17] ? 17'(-acc_next) : acc_next[16:0];
  assign last_field = (af == 3'(tmcs_pkg::NFIELD - 1));

  assign in_ready  = (st == S_IDLE);
  assign cfg_ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      auto_mode   <= 1'b0;
      mpd         <= 6'd24;
      stab_ms     <= 20'd60000;
      first_ms    <= 20'd180000;
      second_ms   <= 20'd480000;
      third_ms    <= 20'd900000;
      phase       <= tmcs_pkg::PH_IDLE;
      elapsed     <= 20'd0;
      last_epoch  <= 32'd0;
      door        <= 1'b0;
      fan         <= 1'b0;
      sched_count <= '0;
      sched_wptr  <= '0;
      samp_valid  <= '0;
      out_valid   <= 1'b0;
      div_req     <= '0;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (st)
        S_IDLE: begin
          if (in_valid) begin
            in_q <= in_data;
            st   <= S_DISP;
          end
        end

        S_DISP: begin
          resp     <= tmcs_pkg::RSP_NONE;
          scan_idx <= '0;
          scan_rv  <= 1'b0;
          st       <= S_OUT;
          if (in_q.opcode == tmcs_pkg::OP_TICK) begin
            if (phase != tmcs_pkg::PH_IDLE) begin
              elapsed <= elapsed_next;
              case (phase)
                tmcs_pkg::PH_PREP: phase <= tmcs_pkg::PH_STAB;
                tmcs_pkg::PH_STAB: begin
                  if (elapsed_next >= stab_ms) phase <= tmcs_pkg::PH_W1;
                end
                tmcs_pkg::PH_W1, tmcs_pkg::PH_W2, tmcs_pkg::PH_W3: begin
                  // latch sample k once its time is reached
                  if (elapsed_next >= ((phase == tmcs_pkg::PH_W1) ? first_ms :
                                       (phase == tmcs_pkg::PH_W2) ? second_ms :
                                                                    third_ms)) begin
                    lk <= 2'(phase - tmcs_pkg::PH_W1);
                    lf <= 3'd0;
                    samp_valid[2'(phase - tmcs_pkg::PH_W1)] <= (in_q.temp_sample != 16'sd0);
                    phase <= phase + 3'd1;
                    st    <= S_LATCH;
                  end
                end
                tmcs_pkg::PH_FIN: begin
                  af   <= 3'd0;
                  step <= 2'd0;
                  acc  <= '0;
                  st   <= S_AVG;
                end
                default: phase <= tmcs_pkg::PH_IDLE;
              endcase
            end else if (auto_mode && (in_q.epoch_seconds > tmcs_pkg::EPOCH_MIN) &&
                         (in_q.epoch_seconds != last_epoch)) begin
              st <= S_SCAN;
            end
          end else if (in_q.opcode == tmcs_pkg::OP_ADD) begin
            st <= S_SCAN;
          end else if (auto_mode) begin
            resp <= (in_q.opcode == tmcs_pkg::OP_FAN_OFF) ? tmcs_pkg::RSP_NONE
                                                          : tmcs_pkg::RSP_IN_AUTO;
          end else begin
            case (in_q.opcode)
              tmcs_pkg::OP_TRIGGER: begin
                if (phase == tmcs_pkg::PH_IDLE) begin
                  phase      <= tmcs_pkg::PH_PREP;
                  elapsed    <= 20'd0;
                  samp_valid <= '0;
                  door       <= 1'b0;
                  fan        <= 1'b1;
                  resp       <= tmcs_pkg::RSP_STARTED;
                end else begin
                  resp <= tmcs_pkg::RSP_BUSY;
                end
              end
              tmcs_pkg::OP_STOP: begin
                phase <= tmcs_pkg::PH_IDLE;
                fan   <= 1'b0;
                door  <= 1'b0;
                resp  <= tmcs_pkg::RSP_STOPPED;
              end
              tmcs_pkg::OP_DOOR_OPN: begin
                door <= 1'b1;
                resp <= tmcs_pkg::RSP_DOOR_OPN;
              end
              tmcs_pkg::OP_DOOR_CLS: begin
                door <= 1'b0;
                resp <= tmcs_pkg::RSP_DOOR_CLS;
              end
              tmcs_pkg::OP_FAN_ON: begin
                fan  <= 1'b1;
                resp <= tmcs_pkg::RSP_FAN_ON;
              end
              default: begin
                fan  <= 1'b0;
                resp <= tmcs_pkg::RSP_FAN_OFF;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_hit || scan_end) begin
            if (in_q.opcode == tmcs_pkg::OP_ADD) begin
              resp <= tmcs_pkg::RSP_SCHED;
              if (scan_end) begin
                // circular table, oldest entry overwritten when full
                sched_wptr <= (sched_wptr == tmcs_pkg::SCHED_AW'(tmcs_pkg::SCHED_SLOTS - 1))
                              ? '0 : sched_wptr + 1'b1;
                if (sched_count != tmcs_pkg::SCHED_CW'(tmcs_pkg::SCHED_SLOTS)) begin
                  sched_count <= sched_count + 1'b1;
                end
              end
              st <= S_OUT;
            end else if (scan_hit) begin
              last_epoch <= in_q.epoch_seconds;
              phase      <= tmcs_pkg::PH_PREP;
              elapsed    <= 20'd0;
              samp_valid <= '0;
              door       <= 1'b0;
              fan        <= 1'b1;
              st         <= S_OUT;
            end else begin
              // grid interval first, then the epoch remainder
              div_req.start    <= 1'b1;
              div_req.dividend <= tmcs_pkg::DAY_SECONDS;
              div_req.divisor  <= 17'(mpd);
              mod_stage        <= 1'b0;
              st               <= S_MOD;
            end
          end else begin
            scan_idx <= scan_idx + 1'b1;
            scan_rv  <= 1'b1;
          end
        end

        S_MOD: begin
          if (div_rsp.done) begin
            if (!mod_stage) begin
              div_req.start    <= 1'b1;
              div_req.dividend <= in_q.epoch_seconds;
              div_req.divisor  <= div_rsp.quot[16:0];
              mod_stage        <= 1'b1;
            end else begin
              if (div_rsp.rem < 17'(tmcs_pkg::GRID_WINDOW_S)) begin
                last_epoch <= in_q.epoch_seconds;
                phase      <= tmcs_pkg::PH_PREP;
                elapsed    <= 20'd0;
                samp_valid <= '0;
                door       <= 1'b0;
                fan        <= 1'b1;
              end
              st <= S_OUT;
            end
          end
        end

        S_LATCH: begin
          lf <= lf + 3'd1;
          if (lf == 3'(tmcs_pkg::NFIELD - 1)) begin
            st <= S_OUT;
          end
        end

        S_AVG: begin
          // read row k of field f, add it in the following cycle when row k is valid
          acc <= acc_next;
          if (step == 2'(tmcs_pkg::NSAMP)) begin
            if (vcnt == 2'd0) begin
              avg[af] <= 16'd0;
              if (last_field) begin
                phase <= tmcs_pkg::PH_IDLE;
                fan   <= 1'b0;
                door  <= 1'b1;
                resp  <= tmcs_pkg::RSP_DATA;
                st    <= S_OUT;
              end else begin
                af   <= af + 3'd1;
                step <= 2'd0;
                acc  <= '0;
              end
            end else begin
              neg              <= acc_next[17];
              div_req.start    <= 1'b1;
              div_req.dividend <= 32'(mag) + 32'(vcnt >> 1);
              div_req.divisor  <= 17'(vcnt);
              st               <= S_DIV;
            end
          end else begin
            step <= step + 2'd1;
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            avg[af] <= neg ? 16'(-div_rsp.quot[15:0]) : div_rsp.quot[15:0];
            if (last_field) begin
              phase <= tmcs_pkg::PH_IDLE;
              fan   <= 1'b0;
              door  <= 1'b1;
              resp  <= tmcs_pkg::RSP_DATA;
              st    <= S_OUT;
            end else begin
              af   <= af + 3'd1;
              step <= 2'd0;
              acc  <= '0;
              st   <= S_AVG;
            end
          end
        end

        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            st        <= S_IDLE;
          end
        end

        default: st <= S_IDLE;
      endcase

      // configuration writes, only while the block is idle
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tmcs_pkg::REG_AUTO: begin
            auto_mode <= cfg_data[0];
            if (!cfg_data[0]) begin
              phase <= tmcs_pkg::PH_IDLE;
              fan   <= 1'b0;
              door  <= 1'b0;
            end
          end
          tmcs_pkg::REG_MPD: begin
            if (cfg_data[5:0] != 6'd0 && cfg_data[5:0] <= tmcs_pkg::MPD_MAX) begin
              mpd <= cfg_data[5:0];
            end
          end
          tmcs_pkg::REG_STAB:   stab_ms   <= cfg_data;
          tmcs_pkg::REG_FIRST:  first_ms  <= cfg_data;
          tmcs_pkg::REG_SECOND: second_ms <= cfg_data;
          tmcs_pkg::REG_THIRD:  third_ms  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // output register, loaded from the relay and phase state, plus averages on data
  always_ff @(posedge clk) begin
    if (st == S_OUT && (!out_valid || out_ready)) begin
      out_data.response    <= resp;
      out_data.door_open   <= door;
      out_data.fan_on      <= fan;
      out_data.cycle_phase <= phase;
      if (resp == tmcs_pkg::RSP_DATA) begin
        out_data.ch4_avg      <= avg[0];
        out_data.co_avg       <= avg[1];
        out_data.alcohol_avg  <= avg[2];
        out_data.nh3_avg      <= avg[3];
        out_data.h2_avg       <= avg[4];
        out_data.temp_avg     <= avg[5];
        out_data.humidity_avg <= avg[6];
      end else begin
        out_data.ch4_avg      <= '0;
        out_data.co_avg       <= '0;
        out_data.alcohol_avg  <= '0;
        out_data.nh3_avg      <= '0;
        out_data.h2_avg       <= '0;
        out_data.temp_avg     <= '0;
        out_data.humidity_avg <= '0;
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the measurement cycle sequencer: a scoreboard class
// predicts every output beat from the accepted input beats and compares
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // behavioral model of the sequencer plus the queue of predicted beats
  class cycle_scoreboard;
    bit          auto_on;
    logic [5:0]  per_day;
    logic [19:0] stab_t, t1, t2, t3;
    logic [2:0]  ph;
    logic [19:0] elapsed;
    logic [31:0] last_epoch;
    logic [4:0]  sh[tmcs_pkg::SCHED_SLOTS];
    logic [5:0]  sm[tmcs_pkg::SCHED_SLOTS];
    logic [5:0]  ss[tmcs_pkg::SCHED_SLOTS];
    int          n_sched;
    logic signed [15:0] store[tmcs_pkg::NSAMP][tmcs_pkg::NFIELD];
    bit          door, fan;
    tmcs_pkg::out_t pending[$];
    int          errors;

    function new();
      auto_on = 0; per_day = 6'd24;
      stab_t = 20'd60000; t1 = 20'd180000; t2 = 20'd480000; t3 = 20'd900000;
      ph = tmcs_pkg::PH_IDLE; elapsed = '0; last_epoch = '0; n_sched = 0;
      door = 0; fan = 0; errors = 0;
      clear_store();
    endfunction

    function void clear_store();
      foreach (store[i, f]) store[i][f] = '0;
    endfunction

    function void halt();
      ph = tmcs_pkg::PH_IDLE; fan = 0; door = 0;
    endfunction

    function void begin_cycle();
      ph = tmcs_pkg::PH_PREP; elapsed = '0; clear_store(); door = 0; fan = 1;
    endfunction

    function void reg_write(logic [2:0] idx, logic [19:0] v);
      case (idx)
        tmcs_pkg::REG_AUTO: begin
          auto_on = v[0];
          if (!auto_on) halt();
        end
        tmcs_pkg::REG_MPD:
          if (v[5:0] >= 6'd1 && v[5:0] <= tmcs_pkg::MPD_MAX) per_day = v[5:0];
        tmcs_pkg::REG_STAB: stab_t = v;
        tmcs_pkg::REG_FIRST: t1 = v;
        tmcs_pkg::REG_SECOND: t2 = v;
        tmcs_pkg::REG_THIRD: t3 = v;
        default: ;
      endcase
    endfunction

    function bit sched_hit(logic [4:0] h, logic [5:0] m, logic [5:0] s);
      for (int i = 0; i < n_sched; i++)
        if (sh[i] == h && sm[i] == m && ss[i] == s) return 1;
      return 0;
    endfunction

    function void grab(int k, tmcs_pkg::in_t d);
      for (int f = 0; f < tmcs_pkg::NFIELD; f++)
        store[k][f] = tmcs_pkg::sample_field(d, f[2:0]);
    endfunction

    // averages over valid samples, rounded half away from zero
    function void fill_averages(ref tmcs_pkg::out_t o);
      int sum[tmcs_pkg::NFIELD];
      int cnt, mag, q;
      logic signed [15:0] av[tmcs_pkg::NFIELD];
      cnt = 0;
      foreach (sum[f]) sum[f] = 0;
      for (int i = 0; i < tmcs_pkg::NSAMP; i++)
        if (store[i][tmcs_pkg::TEMP_FIELD] != 0) begin
          for (int f = 0; f < tmcs_pkg::NFIELD; f++) sum[f] += store[i][f];
          cnt++;
        end
      for (int f = 0; f < tmcs_pkg::NFIELD; f++) begin
        av[f] = '0;
        if (cnt > 0) begin
          mag = sum[f] < 0 ? -sum[f] : sum[f];
          q = (mag + cnt / 2) / cnt;
          av[f] = 16'(sum[f] < 0 ? -q : q);
        end
      end
      o.ch4_avg = av[0]; o.co_avg = av[1]; o.alcohol_avg = av[2];
      o.nh3_avg = av[3]; o.h2_avg = av[4]; o.temp_avg = av[5];
      o.humidity_avg = av[6];
    endfunction

    function void note_input(tmcs_pkg::in_t d);
      tmcs_pkg::out_t o;
      logic [31:0] iv;
      o = '0;
      o.response = tmcs_pkg::RSP_NONE;
      case (d.opcode)
        tmcs_pkg::OP_TICK: begin
          if (ph != tmcs_pkg::PH_IDLE) begin
            if (elapsed != tmcs_pkg::ELAPSED_MAX) elapsed++;
            case (ph)
              tmcs_pkg::PH_PREP: ph = tmcs_pkg::PH_STAB;
              tmcs_pkg::PH_STAB: if (elapsed >= stab_t) ph = tmcs_pkg::PH_W1;
              tmcs_pkg::PH_W1:
                if (elapsed >= t1) begin grab(0, d); ph = tmcs_pkg::PH_W2; end
              tmcs_pkg::PH_W2:
                if (elapsed >= t2) begin grab(1, d); ph = tmcs_pkg::PH_W3; end
              tmcs_pkg::PH_W3:
                if (elapsed >= t3) begin grab(2, d); ph = tmcs_pkg::PH_FIN; end
              tmcs_pkg::PH_FIN: begin
                fill_averages(o);
                o.response = tmcs_pkg::RSP_DATA;
                ph = tmcs_pkg::PH_IDLE; fan = 0; door = 1;
              end
              default: ph = tmcs_pkg::PH_IDLE;
            endcase
          end else if (auto_on && d.epoch_seconds > tmcs_pkg::EPOCH_MIN &&
                       d.epoch_seconds != last_epoch) begin
            iv = tmcs_pkg::DAY_SECONDS / per_day;
            if (sched_hit(d.hour, d.minute, d.second) ||
                (d.epoch_seconds % iv) < 32'(tmcs_pkg::GRID_WINDOW_S)) begin
              last_epoch = d.epoch_seconds;
              begin_cycle();
            end
          end
        end
        tmcs_pkg::OP_ADD: begin
          if (!sched_hit(d.hour, d.minute, d.second)) begin
            // full table drops its oldest entry
            if (n_sched >= tmcs_pkg::SCHED_SLOTS) begin
              for (int i = 0; i < tmcs_pkg::SCHED_SLOTS - 1; i++) begin
                sh[i] = sh[i+1]; sm[i] = sm[i+1]; ss[i] = ss[i+1];
              end
              n_sched = tmcs_pkg::SCHED_SLOTS - 1;
            end
            sh[n_sched] = d.hour; sm[n_sched] = d.minute; ss[n_sched] = d.second;
            n_sched++;
          end
          o.response = tmcs_pkg::RSP_SCHED;
        end
        default: begin
          if (auto_on)
            o.response = (d.opcode == tmcs_pkg::OP_FAN_OFF) ? tmcs_pkg::RSP_NONE
                                                            : tmcs_pkg::RSP_IN_AUTO;
          else case (d.opcode)
            tmcs_pkg::OP_TRIGGER: if (ph == tmcs_pkg::PH_IDLE) begin
              begin_cycle(); o.response = tmcs_pkg::RSP_STARTED;
            end else o.response = tmcs_pkg::RSP_BUSY;
            tmcs_pkg::OP_STOP: begin halt(); o.response = tmcs_pkg::RSP_STOPPED; end
            tmcs_pkg::OP_DOOR_OPN: begin door = 1; o.response = tmcs_pkg::RSP_DOOR_OPN; end
            tmcs_pkg::OP_DOOR_CLS: begin door = 0; o.response = tmcs_pkg::RSP_DOOR_CLS; end
            tmcs_pkg::OP_FAN_ON: begin fan = 1; o.response = tmcs_pkg::RSP_FAN_ON; end
            default: begin fan = 0; o.response = tmcs_pkg::RSP_FAN_OFF; end
          endcase
        end
      endcase
      o.door_open = door; o.fan_on = fan; o.cycle_phase = ph;
      pending = {pending, o};
    endfunction

    function void check_result(tmcs_pkg::out_t got);
      tmcs_pkg::out_t exp_beat;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat %h", got);
        return;
      end
      exp_beat = pending.pop_front();
      if (got !== exp_beat) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp resp %0d door %0d fan %0d ph %0d avg %h",
                    " | got resp %0d door %0d fan %0d ph %0d avg %h"},
                   exp_beat.response, exp_beat.door_open, exp_beat.fan_on,
                   exp_beat.cycle_phase, exp_beat[111:0],
                   got.response, got.door_open, got.fan_on, got.cycle_phase,
                   got[111:0]);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  tmcs_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  tmcs_pkg::out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  cycle_scoreboard sb = new();
  int  idle_cycles = 0;
  int  watchdog_limit = 40000;
  bit  timed_out = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  timed_measurement_cycle_sequencer_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // random gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // output side: check on accepted beats, random backpressure
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g == 0) out_ready <= 1;
      else begin
        out_ready <= 0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // watchdog on cycles with no beat moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > watchdog_limit && !timed_out) begin
      timed_out = 1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one input beat, held until accepted, then predicted
  task automatic send_item(tmcs_pkg::in_t d);
    repeat (gap_len() + 1) @(negedge clk);
    in_valid <= 1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_input(d);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    // let the block settle before the next settings change
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.reg_write(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic tmcs_pkg::in_t rand_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(tmcs_pkg::in_t)-1:0];
  endfunction

  function automatic tmcs_pkg::in_t tick(logic [31:0] ep, logic [4:0] h, logic [5:0] m,
                                         logic [5:0] s);
    tmcs_pkg::in_t d;
    d = rand_item();
    d.opcode = tmcs_pkg::OP_TICK;
    d.epoch_seconds = ep; d.hour = h; d.minute = m; d.second = s;
    // some samples invalid
    if ($urandom_range(0, 4) == 0) d.temp_sample = '0;
    return d;
  endfunction

  function automatic tmcs_pkg::in_t cmd(logic [2:0] op);
    tmcs_pkg::in_t d;
    d = rand_item();
    d.opcode = op;
    return d;
  endfunction

  // short timing profile so cycles finish within a few dozen ticks
  task automatic short_timing();
    write_reg(tmcs_pkg::REG_STAB, 20'($urandom_range(0, 4)));
    write_reg(tmcs_pkg::REG_FIRST, 20'($urandom_range(0, 8)));
    write_reg(tmcs_pkg::REG_SECOND, 20'($urandom_range(0, 12)));
    write_reg(tmcs_pkg::REG_THIRD, 20'($urandom_range(0, 16)));
  endtask

  // a run of n ticks with consecutive epoch seconds and random times of day
  task automatic run_ticks(int n, logic [31:0] ep);
    for (int i = 0; i < n; i++)
      send_item(tick(ep + 32'(i), 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                     6'($urandom_range(0, 59))));
  endtask

  initial begin
    tmcs_pkg::in_t d;
    logic [31:0] ep;
    int r;
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: manual commands with default timing, extremes of fields
    send_item(cmd(tmcs_pkg::OP_DOOR_OPN));
    send_item(cmd(tmcs_pkg::OP_DOOR_CLS));
    send_item(cmd(tmcs_pkg::OP_FAN_ON));
    send_item(cmd(tmcs_pkg::OP_FAN_OFF));
    send_item(cmd(tmcs_pkg::OP_STOP));
    d = tick(32'hFFFF_FFFF, 5'd31, 6'd63, 6'd63); send_item(d);
    d = tick(32'd0, 5'd0, 6'd0, 6'd0); send_item(d);
    d = cmd(tmcs_pkg::OP_ADD); d.hour = 5'd31; d.minute = 6'd63; d.second = 6'd63;
    send_item(d);
    send_item(d); // duplicate entry is not stored again
    wait_drained();
    write_reg(tmcs_pkg::REG_AUTO, 20'd0);
    write_reg(tmcs_pkg::REG_MPD, 20'd0);  // ignored
    write_reg(tmcs_pkg::REG_MPD, 20'd63); // ignored
    write_reg(tmcs_pkg::REG_STAB, 20'd0);
    write_reg(tmcs_pkg::REG_FIRST, 20'd0);
    write_reg(tmcs_pkg::REG_SECOND, 20'd0);
    write_reg(tmcs_pkg::REG_THIRD, 20'hFFFFF);
    send_item(cmd(tmcs_pkg::OP_TRIGGER));
    send_item(cmd(tmcs_pkg::OP_TRIGGER)); // busy
    run_ticks(6, 32'd5);
    send_item(cmd(tmcs_pkg::OP_STOP));
    wait_drained();
    write_reg(tmcs_pkg::REG_THIRD, 20'd0);
    send_item(cmd(tmcs_pkg::OP_TRIGGER));
    d = tick(32'd1, 5'd0, 6'd0, 6'd0);
    d.temp_sample = 16'sh8000; d.ch4_sample = 16'sh7FFF;
    run_ticks(3, 32'd7);
    send_item(d); send_item(d);
    wait_drained();
    // auto mode: commands answer in auto, grid start at per_day 48
    write_reg(tmcs_pkg::REG_AUTO, 20'd1);
    write_reg(tmcs_pkg::REG_MPD, 20'd48);
    send_item(cmd(tmcs_pkg::OP_TRIGGER));
    send_item(cmd(tmcs_pkg::OP_FAN_OFF));
    send_item(tick(32'd100000, 5'd0, 6'd0, 6'd0)); // not above threshold
    send_item(tick(32'd100800, 5'd0, 6'd0, 6'd0)); // grid slot
    run_ticks(8, 32'd100801);
    wait_drained();
    write_reg(tmcs_pkg::REG_MPD, 20'd1);
    write_reg(tmcs_pkg::REG_MPD, 20'd24);

    // random phases with varied settings
    for (int ph_i = 0; ph_i < 14; ph_i++) begin
      wait_drained();
      write_reg(tmcs_pkg::REG_AUTO, 20'($urandom_range(0, 1)));
      r = $urandom_range(0, 3);
      write_reg(tmcs_pkg::REG_MPD, 20'(r == 0 ? 1 : r == 1 ? 48 : $urandom_range(0, 63)));
      short_timing();
      ep = $urandom_range(0, 3) == 0 ? $urandom : 32'd100000 + $urandom_range(0, 200000);
      for (int k = 0; k < 100; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // runs of consecutive seconds reach grid slots and schedules
          d = tick(ep, 5'($urandom_range(0, 2)), 6'($urandom_range(0, 2)),
                   6'($urandom_range(0, 3)));
          if ($urandom_range(0, 3) != 0) ep = ep + 32'd1;
        end else if (r < 80) begin
          d = cmd(tmcs_pkg::OP_ADD);
          if ($urandom_range(0, 1)) begin
            d.hour = 5'($urandom_range(0, 2)); d.minute = 6'($urandom_range(0, 2));
            d.second = 6'($urandom_range(0, 3));
          end
        end else d = cmd(3'($urandom_range(2, 7)));
        send_item(d);
        // hold off until every beat is back
        if (k == 50) begin
          while (sb.pending.size() != 0) @(negedge clk);
        end
      end
    end

    wait_drained();
    repeat (2000) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
